[rtl/assert_macros.svh]
// Assertion macros shared by the level meter RTL.
// Expects clk and rst_n in scope at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// General property, checked out of reset.
`define ALM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication, checked out of reset.
`define ALM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

[rtl/alm_pkg.sv]
// Shared types and constants of the audio level meter.
// No dependencies; every RTL source but assert_macros.svh refers to it by scoped names.
package alm_pkg;

  localparam int SAMPLE_W          = 16;
  localparam int SUM_W             = 43;
  localparam int CNT_W             = 13;
  localparam int LVL_W             = 16;
  localparam int TS_W              = 64;
  localparam int PTS_W             = 63;
  localparam int CH_W              = 4;
  localparam int RATE_W            = 18;
  localparam int CFG_IDX_W         = 4;
  localparam int CFG_DATA_W        = 18;
  localparam int MAX_CHUNK_SAMPLES = 4096;
  localparam int FULL_SCALE        = 32768;
  localparam int PEAK_DECAY        = 58982;
  localparam int TICKS_PER_SEC     = 10000000;

  // Shared divide / square root unit
  localparam int SH_W   = 43;
  localparam int REM_W  = 19;
  localparam int ROOT_W = 16;
  localparam int STEP_W = 6;
  localparam int DUR_W  = 36;
  localparam int MEAN_W = 32;

  localparam logic [STEP_W-1:0] MEAN_STEPS  = STEP_W'(SH_W);
  localparam logic [STEP_W-1:0] SQRT_STEPS  = STEP_W'(ROOT_W);
  localparam logic [STEP_W-1:0] FRAME_STEPS = STEP_W'(CNT_W);
  localparam logic [STEP_W-1:0] DUR_STEPS   = STEP_W'(DUR_W);

  localparam logic [CH_W-1:0]   CH_RESET   = CH_W'(2);
  localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(48000);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHANNEL_COUNT = 4'd0,
    REG_SAMPLE_RATE   = 4'd1
  } reg_idx_t;

  typedef enum logic {
    OP_DIV  = 1'b0,
    OP_SQRT = 1'b1
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MEAN_LD,
    S_MEAN,
    S_SQRT_LD,
    S_SQRT,
    S_FRM_LD,
    S_FRM,
    S_DUR_LD,
    S_DUR,
    S_WB
  } state_t;

  typedef struct packed {
    logic              start;
    op_t               op;
    logic [STEP_W-1:0] steps;
  } iter_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } iter_rsp_t;

  typedef struct packed {
    logic take;
    logic clear;
  } acc_ctl_t;

endpackage

[rtl/alm_ifs.sv]
// Channel interfaces of the audio level meter: input, result and config write.
// Depends on alm_pkg for field widths.
interface alm_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [alm_pkg::SAMPLE_W-1:0] sample;
  logic                                has_sample;
  logic                                last_of_chunk;
  logic                                forward_chunk;

  modport source (output valid, sample, has_sample, last_of_chunk, forward_chunk,
                  input ready);
  modport sink   (input valid, sample, has_sample, last_of_chunk, forward_chunk,
                  output ready);
endinterface

interface alm_out_if;
  logic                        valid;
  logic                        ready;
  logic [alm_pkg::LVL_W-1:0]   rms_level;
  logic [alm_pkg::LVL_W-1:0]   peak_level;
  logic [alm_pkg::PTS_W-1:0]   chunk_pts;
  logic                        pts_advanced;
  logic [alm_pkg::CNT_W-1:0]   chunk_samples;

  modport source (output valid, rms_level, peak_level, chunk_pts, pts_advanced,
                  chunk_samples, input ready);
  modport sink   (input valid, rms_level, peak_level, chunk_pts, pts_advanced,
                  chunk_samples, output ready);
endinterface

interface alm_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [alm_pkg::CFG_IDX_W-1:0]    index;
  logic [alm_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/audio_level_meter_with_pts.sv]
// Audio RMS/peak level meter with presentation timestamp.
// Input channel in_if carries one signed Q1.15 sample per transaction with
// has_sample, last_of_chunk and forward_chunk flags; a chunk ends on the
// transaction with last_of_chunk set (a bare end has has_sample low).
// Result channel out_if gives one transaction per chunk end: smoothed RMS,
// held peak, timestamp before the advance, advance flag and sample count.
// Config channel cfg_if writes channel_count (index 0) and sample_rate_hz
// (index 1); it is always ready, other indexes are dropped.
// in_if.ready is high while the sequencer is idle, so transactions without
// last_of_chunk are taken back to back. A chunk end runs on one shared
// divide/square-root unit, in passes for the mean square and the root
// (skipped for an empty chunk) and, when forwarded, for frames and the
// timestamp advance, each pass a load state and then its steps; a write-back
// ends the run. in_if.ready is low from the chunk end until the write-back.
// The result sits in an output register; a stalled receiver holds it, and
// samples of the next chunk are still taken, while a further chunk end waits
// in write-back until the register frees.
// Reset (synchronous, rst_n low) clears the smoothed and held levels, the timestamp
// and the running chunk, and loads channel_count 2 and sample_rate_hz 48000.
`include "assert_macros.svh"

module audio_level_meter_with_pts (
  input  logic         clk,
  input  logic         rst_n,
  alm_in_if.sink       in_if,
  alm_out_if.source    out_if,
  alm_cfg_if.sink      cfg_if
);

  alm_pkg::state_t                  state_r, state_nxt;
  alm_pkg::iter_req_t               req;
  alm_pkg::iter_rsp_t               rsp;
  alm_pkg::acc_ctl_t                acc_ctl;
  logic [alm_pkg::SH_W-1:0]         unit_dividend, unit_q;
  logic [alm_pkg::RATE_W-1:0]       unit_divisor;
  logic [alm_pkg::ROOT_W-1:0]       unit_root;

  logic [alm_pkg::SUM_W-1:0]        acc_sum;
  logic [alm_pkg::LVL_W-1:0]        acc_peak;
  logic [alm_pkg::CNT_W-1:0]        acc_cnt;

  logic [alm_pkg::CH_W-1:0]         ch_r;
  logic [alm_pkg::RATE_W-1:0]       rate_r;
  logic [alm_pkg::CH_W-1:0]         ch_eff;
  logic [alm_pkg::RATE_W-1:0]       rate_eff;

  logic                             fwd_r;
  logic [alm_pkg::LVL_W-1:0]        rms_r;
  logic [alm_pkg::CNT_W-1:0]        frames_r;
  logic [alm_pkg::DUR_W-1:0]        dur_r;
  logic [alm_pkg::DUR_W-1:0]        dur_prod;
  logic [alm_pkg::LVL_W-1:0]        smoothed_r;
  logic [alm_pkg::LVL_W-1:0]        held_r;
  logic [alm_pkg::TS_W-1:0]         ts_r;

  logic                             out_valid_r, out_valid_nxt;
  logic [alm_pkg::LVL_W-1:0]        out_rms_r, out_peak_r;
  logic [alm_pkg::PTS_W-1:0]        out_pts_r;
  logic                             out_adv_r;
  logic [alm_pkg::CNT_W-1:0]        out_cnt_r;

  logic                             in_acc, cfg_acc, wb_go;
  logic [alm_pkg::LVL_W+1:0]        sm_sum;
  logic [alm_pkg::LVL_W-1:0]        sm_new, pk_new, pk_max, decayed;
  logic [2*alm_pkg::LVL_W-1:0]      decay_prod;
  logic                             unit_wait, wb_done_ok, lvl_ok;

  assign in_acc  = in_if.valid && in_if.ready;
  assign cfg_acc = cfg_if.valid && cfg_if.ready;
  assign ch_eff   = (ch_r == '0) ? alm_pkg::CH_W'(1) : ch_r;
  assign rate_eff = (rate_r == '0) ? alm_pkg::RATE_W'(1) : rate_r;
  assign dur_prod = alm_pkg::DUR_W'(frames_r) * alm_pkg::DUR_W'(alm_pkg::TICKS_PER_SEC);

  alm_accum u_accum (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (acc_ctl),
    .sample (in_if.sample),
    .sum    (acc_sum),
    .peak   (acc_peak),
    .count  (acc_cnt)
  );

  alm_iter_unit u_iter (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (req),
    .dividend (unit_dividend),
    .divisor  (unit_divisor),
    .rsp      (rsp),
    .quotient (unit_q),
    .root     (unit_root)
  );

  // Configuration registers
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_r   <= alm_pkg::CH_RESET;
      rate_r <= alm_pkg::RATE_RESET;
    end else if (cfg_acc) begin
      unique case (cfg_if.index)
        alm_pkg::REG_CHANNEL_COUNT: ch_r   <= cfg_if.data[alm_pkg::CH_W-1:0];
        alm_pkg::REG_SAMPLE_RATE:   rate_r <= cfg_if.data;
        default: ;
      endcase
    end
  end

  // Sequencer: next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      alm_pkg::S_IDLE:    if (in_acc && in_if.last_of_chunk) state_nxt = alm_pkg::S_MEAN_LD;
      alm_pkg::S_MEAN_LD: state_nxt = (acc_cnt == '0) ? alm_pkg::S_FRM_LD : alm_pkg::S_MEAN;
      alm_pkg::S_MEAN:    if (rsp.done) state_nxt = alm_pkg::S_SQRT_LD;
      alm_pkg::S_SQRT_LD: state_nxt = alm_pkg::S_SQRT;
      alm_pkg::S_SQRT:    if (rsp.done) state_nxt = alm_pkg::S_FRM_LD;
      alm_pkg::S_FRM_LD:  state_nxt = fwd_r ? alm_pkg::S_FRM : alm_pkg::S_WB;
      alm_pkg::S_FRM:     if (rsp.done) state_nxt = alm_pkg::S_DUR_LD;
      alm_pkg::S_DUR_LD:  state_nxt = alm_pkg::S_DUR;
      alm_pkg::S_DUR:     if (rsp.done) state_nxt = alm_pkg::S_WB;
      alm_pkg::S_WB:      if (wb_go) state_nxt = alm_pkg::S_IDLE;
      default:            state_nxt = alm_pkg::S_IDLE;
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    req           = '{start: 1'b0, op: alm_pkg::OP_DIV, steps: '0};
    unit_dividend = '0;
    unit_divisor  = '0;
    in_if.ready   = 1'b0;
    wb_go         = 1'b0;
    unique case (state_r)
      alm_pkg::S_IDLE: in_if.ready = 1'b1;
      alm_pkg::S_MEAN_LD: begin
        req.start     = (acc_cnt != '0);
        req.steps     = alm_pkg::MEAN_STEPS;
        unit_dividend = acc_sum;
        unit_divisor  = alm_pkg::RATE_W'(acc_cnt);
      end
      alm_pkg::S_SQRT_LD: begin
        // Mean square is at most 2^30; root it from the top of the word
        req.start     = 1'b1;
        req.op        = alm_pkg::OP_SQRT;
        req.steps     = alm_pkg::SQRT_STEPS;
        unit_dividend = {unit_q[alm_pkg::MEAN_W-1:0], (alm_pkg::SH_W-alm_pkg::MEAN_W)'(0)};
      end
      alm_pkg::S_FRM_LD: begin
        req.start     = fwd_r;
        req.steps     = alm_pkg::FRAME_STEPS;
        unit_dividend = {acc_cnt, (alm_pkg::SH_W-alm_pkg::CNT_W)'(0)};
        unit_divisor  = alm_pkg::RATE_W'(ch_eff);
      end
      alm_pkg::S_DUR_LD: begin
        req.start     = 1'b1;
        req.steps     = alm_pkg::DUR_STEPS;
        unit_dividend = {dur_prod, (alm_pkg::SH_W-alm_pkg::DUR_W)'(0)};
        unit_divisor  = rate_eff;
      end
      alm_pkg::S_WB: wb_go = !out_valid_r || out_if.ready;
      default: ;
    endcase
  end

  assign acc_ctl.take  = in_acc && in_if.has_sample;
  assign acc_ctl.clear = wb_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= alm_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Chunk-end intermediates
  always_ff @(posedge clk) begin
    if (in_acc && in_if.last_of_chunk) begin
      fwd_r <= in_if.forward_chunk;
    end
    if (state_r == alm_pkg::S_MEAN_LD && acc_cnt == '0) begin
      rms_r <= '0;
    end else if (state_r == alm_pkg::S_SQRT && rsp.done) begin
      rms_r <= unit_root;
    end
    if (state_r == alm_pkg::S_FRM && rsp.done) begin
      frames_r <= unit_q[alm_pkg::CNT_W-1:0];
    end
    if (state_r == alm_pkg::S_DUR && rsp.done) begin
      dur_r <= unit_q[alm_pkg::DUR_W-1:0];
    end
  end

  // Smoothing and peak hold
  always_comb begin
    sm_sum = {2'b00, smoothed_r} + {1'b0, smoothed_r, 1'b0} + {2'b00, rms_r};
    sm_new = sm_sum[alm_pkg::LVL_W+1:2];
    if (sm_new > alm_pkg::LVL_W'(alm_pkg::FULL_SCALE)) begin
      sm_new = alm_pkg::LVL_W'(alm_pkg::FULL_SCALE);
    end
    decay_prod = held_r * alm_pkg::LVL_W'(alm_pkg::PEAK_DECAY);
    decayed    = decay_prod[2*alm_pkg::LVL_W-1:alm_pkg::LVL_W];
    pk_max     = (acc_peak > decayed) ? acc_peak : decayed;
    pk_new     = (pk_max > alm_pkg::LVL_W'(alm_pkg::FULL_SCALE))
                 ? alm_pkg::LVL_W'(alm_pkg::FULL_SCALE) : pk_max;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smoothed_r <= '0;
      held_r     <= '0;
      ts_r       <= '0;
    end else if (wb_go) begin
      smoothed_r <= sm_new;
      held_r     <= pk_new;
      if (fwd_r) begin
        ts_r <= ts_r + alm_pkg::TS_W'(dur_r);
      end
    end
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (wb_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wb_go) begin
      out_rms_r  <= sm_new;
      out_peak_r <= pk_new;
      out_pts_r  <= ts_r[alm_pkg::PTS_W-1:0];
      out_adv_r  <= fwd_r;
      out_cnt_r  <= acc_cnt;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.rms_level     = out_rms_r;
  assign out_if.peak_level    = out_peak_r;
  assign out_if.chunk_pts     = out_pts_r;
  assign out_if.pts_advanced  = out_adv_r;
  assign out_if.chunk_samples = out_cnt_r;

  assign unit_wait  = (state_r == alm_pkg::S_MEAN) || (state_r == alm_pkg::S_SQRT) ||
                      (state_r == alm_pkg::S_FRM) || (state_r == alm_pkg::S_DUR);
  assign wb_done_ok = (acc_cnt == '0) && out_valid_r && (state_r == alm_pkg::S_IDLE);
  assign lvl_ok     = (out_rms_r <= alm_pkg::LVL_W'(alm_pkg::FULL_SCALE)) &&
                      (out_peak_r <= alm_pkg::LVL_W'(alm_pkg::FULL_SCALE));

  `ALM_ASSERT_IMPL(a_done_in_wait, rsp.done, unit_wait, "unit finished outside a wait state")
  `ALM_ASSERT(a_wb_clears, wb_go |=> wb_done_ok, "write-back did not clear chunk")
  `ALM_ASSERT_IMPL(a_lvl_range, out_valid_r, lvl_ok, "level above full scale")

endmodule

[rtl/alm_iter_unit.sv]
// Shared iterative unit: restoring division (one quotient bit per cycle)
// or digit-by-digit square root (one root bit per cycle). Uses alm_pkg.
`include "assert_macros.svh"

module alm_iter_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  alm_pkg::iter_req_t             req,
  input  logic [alm_pkg::SH_W-1:0]       dividend,
  input  logic [alm_pkg::RATE_W-1:0]     divisor,
  output alm_pkg::iter_rsp_t             rsp,
  output logic [alm_pkg::SH_W-1:0]       quotient,
  output logic [alm_pkg::ROOT_W-1:0]     root
);

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  alm_pkg::op_t                  op_r;
  logic [alm_pkg::STEP_W-1:0]    cnt_r;
  logic [alm_pkg::REM_W-1:0]     rem_r, rem_nxt;
  logic [alm_pkg::SH_W-1:0]      sh_r, sh_nxt;
  logic [alm_pkg::ROOT_W-1:0]    root_r, root_nxt;
  logic [alm_pkg::RATE_W-1:0]    div_r;
  logic [alm_pkg::REM_W-1:0]     op_a, op_b;
  logic [alm_pkg::REM_W:0]       diff;
  logic                          ge;

  // One compare/subtract serves both operations
  always_comb begin
    if (op_r == alm_pkg::OP_DIV) begin
      op_a = {rem_r[alm_pkg::REM_W-2:0], sh_r[alm_pkg::SH_W-1]};
      op_b = {1'b0, div_r};
    end else begin
      op_a = {rem_r[alm_pkg::REM_W-3:0], sh_r[alm_pkg::SH_W-1 -: 2]};
      op_b = {1'b0, root_r, 2'b01};
    end
    diff = {1'b0, op_a} - {1'b0, op_b};
    ge   = ~diff[alm_pkg::REM_W];
  end

  always_comb begin
    rem_nxt  = ge ? diff[alm_pkg::REM_W-1:0] : op_a;
    root_nxt = {root_r[alm_pkg::ROOT_W-2:0], ge};
    if (op_r == alm_pkg::OP_DIV) begin
      sh_nxt = {sh_r[alm_pkg::SH_W-2:0], ge};
    end else begin
      sh_nxt = {sh_r[alm_pkg::SH_W-3:0], 2'b00};
    end
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      busy_nxt = 1'b1;
    end else if (busy_r && cnt_r == alm_pkg::STEP_W'(1)) begin
      busy_nxt = 1'b0;
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      op_r   <= req.op;
      cnt_r  <= req.steps;
      rem_r  <= '0;
      sh_r   <= dividend;
      root_r <= '0;
      div_r  <= divisor;
    end else if (busy_r) begin
      cnt_r  <= cnt_r - alm_pkg::STEP_W'(1);
      rem_r  <= rem_nxt;
      sh_r   <= sh_nxt;
      if (op_r == alm_pkg::OP_SQRT) begin
        root_r <= root_nxt;
      end
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign quotient = sh_r;
  assign root     = root_r;

  `ALM_ASSERT_IMPL(a_no_restart, req.start, !busy_r, "iter unit restarted while busy")

endmodule

[rtl/alm_accum.sv]
// Per-chunk accumulator: absolute peak, sum of squares and saturating count.
// Uses alm_pkg; one sample per cycle.
`include "assert_macros.svh"

module alm_accum (
  input  logic                              clk,
  input  logic                              rst_n,
  input  alm_pkg::acc_ctl_t                 ctl,
  input  logic signed [alm_pkg::SAMPLE_W-1:0] sample,
  output logic [alm_pkg::SUM_W-1:0]         sum,
  output logic [alm_pkg::LVL_W-1:0]         peak,
  output logic [alm_pkg::CNT_W-1:0]         count
);

  logic [alm_pkg::SUM_W-1:0]       sum_r, sum_nxt;
  logic [alm_pkg::LVL_W-1:0]       peak_r, peak_nxt;
  logic [alm_pkg::CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [alm_pkg::LVL_W-1:0]       mag;
  logic [2*alm_pkg::LVL_W-1:0]     sq;
  logic                            room;

  always_comb begin
    // Two's complement magnitude; full negative scale maps to 32768
    mag  = sample[alm_pkg::SAMPLE_W-1] ? (~sample + 1'b1) : sample;
    sq   = mag * mag;
    room = cnt_r < alm_pkg::CNT_W'(alm_pkg::MAX_CHUNK_SAMPLES);
    sum_nxt  = sum_r;
    peak_nxt = peak_r;
    cnt_nxt  = cnt_r;
    if (ctl.clear) begin
      sum_nxt  = '0;
      peak_nxt = '0;
      cnt_nxt  = '0;
    end else if (ctl.take) begin
      if (mag > peak_r) begin
        peak_nxt = mag;
      end
      if (room) begin
        sum_nxt = sum_r + alm_pkg::SUM_W'(sq);
        cnt_nxt = cnt_r + alm_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      peak_r <= '0;
      cnt_r  <= '0;
    end else begin
      sum_r  <= sum_nxt;
      peak_r <= peak_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  assign sum   = sum_r;
  assign peak  = peak_r;
  assign count = cnt_r;

  `ALM_ASSERT(a_cnt_sat, cnt_r <= alm_pkg::CNT_W'(alm_pkg::MAX_CHUNK_SAMPLES), "count past max")

endmodule

[tb/alm_level_checker.sv]
// Scoreboard for the audio level meter: watches the input, result and config
// channels, predicts one result per chunk end and compares field by field.
// Depends on alm_pkg for widths, register indexes and constants.
`timescale 1ns / 1ps

module alm_level_checker
  import alm_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic                       in_has_sample,
  input  logic                       in_last_of_chunk,
  input  logic                       in_forward_chunk,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic [LVL_W-1:0]           out_rms_level,
  input  logic [LVL_W-1:0]           out_peak_level,
  input  logic [PTS_W-1:0]           out_chunk_pts,
  input  logic                       out_pts_advanced,
  input  logic [CNT_W-1:0]           out_chunk_samples,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  output int                         mismatches,
  output int                         results_due
);

  localparam int MAX_PRINTED = 50;

  typedef struct packed {
    logic [LVL_W-1:0] rms;
    logic [LVL_W-1:0] peak;
    logic [PTS_W-1:0] pts;
    logic             advanced;
    logic [CNT_W-1:0] count;
  } level_result_t;

  level_result_t levels_due[$];
  level_result_t due;

  logic [SUM_W-1:0]  sq_sum;
  logic [LVL_W-1:0]  chunk_pk;
  logic [CNT_W-1:0]  n_taken;
  logic [LVL_W-1:0]  rms_avg;
  logic [LVL_W-1:0]  peak_hold;
  logic [TS_W-1:0]   pts_now;
  logic [CH_W-1:0]   n_channels;
  logic [RATE_W-1:0] rate_hz;
  logic [LVL_W-1:0]  mag;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTED) begin
      $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    end
  endtask

  // Floor square root, one result bit at a time from the top.
  function automatic logic [LVL_W-1:0] root_floor(input logic [63:0] v);
    logic [31:0] r;
    logic [31:0] t;
    r = '0;
    for (int b = LVL_W - 1; b >= 0; b--) begin
      t = r | (32'd1 << b);
      if (64'(t) * 64'(t) <= v) r = t;
    end
    return r[LVL_W-1:0];
  endfunction

  task automatic close_chunk(input logic fwd);
    logic [LVL_W-1:0] rms;
    logic [31:0]      sm;
    logic [63:0]      decayed;
    logic [63:0]      pk;
    logic [63:0]      frames;
    logic [63:0]      ch;
    logic [63:0]      rate;
    level_result_t    r;
    rms = (n_taken != 0) ? root_floor(64'(sq_sum) / 64'(n_taken)) : '0;
    sm = (32'(rms_avg) * 32'd3 + 32'(rms)) >> 2;
    if (sm > FULL_SCALE) sm = FULL_SCALE;
    rms_avg = sm[LVL_W-1:0];
    decayed = (64'(peak_hold) * 64'(PEAK_DECAY)) >> 16;
    pk = (64'(chunk_pk) > decayed) ? 64'(chunk_pk) : decayed;
    if (pk > FULL_SCALE) pk = FULL_SCALE;
    peak_hold = pk[LVL_W-1:0];
    r.rms      = rms_avg;
    r.peak     = peak_hold;
    r.pts      = pts_now[PTS_W-1:0];
    r.advanced = fwd;
    r.count    = n_taken;
    if (fwd) begin
      ch      = (n_channels == 0) ? 64'd1 : 64'(n_channels);
      rate    = (rate_hz == 0) ? 64'd1 : 64'(rate_hz);
      frames  = 64'(n_taken) / ch;
      pts_now = pts_now + frames * 64'(TICKS_PER_SEC) / rate;
    end
    levels_due = {levels_due, r};
    sq_sum   = '0;
    chunk_pk = '0;
    n_taken  = '0;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      levels_due.delete();
      sq_sum     = '0;
      chunk_pk   = '0;
      n_taken    = '0;
      rms_avg    = '0;
      peak_hold  = '0;
      pts_now    = '0;
      n_channels = CH_RESET;
      rate_hz    = RATE_RESET;
      mismatches = 0;
    end else begin
      // Retire first: a chunk end taken at this edge cannot be answered at the same edge.
      if (out_valid && out_ready) begin
        if (levels_due.size() == 0) begin
          report("result with nothing due (chunk_samples)", 64'(out_chunk_samples), '0);
        end else begin
          due = levels_due.pop_front();
          if (out_rms_level !== due.rms) report("rms_level", 64'(out_rms_level), 64'(due.rms));
          if (out_peak_level !== due.peak) begin
            report("peak_level", 64'(out_peak_level), 64'(due.peak));
          end
          if (out_chunk_pts !== due.pts) report("chunk_pts", 64'(out_chunk_pts), 64'(due.pts));
          if (out_pts_advanced !== due.advanced) begin
            report("pts_advanced", 64'(out_pts_advanced), 64'(due.advanced));
          end
          if (out_chunk_samples !== due.count) begin
            report("chunk_samples", 64'(out_chunk_samples), 64'(due.count));
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CHANNEL_COUNT: n_channels = cfg_data[CH_W-1:0];
          REG_SAMPLE_RATE:   rate_hz = cfg_data[RATE_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (in_has_sample) begin
          mag = (in_sample < 0) ? LVL_W'(-in_sample) : LVL_W'(in_sample);
          if (mag > chunk_pk) chunk_pk = mag;
          // Saturated chunk: keep tracking the peak only.
          if (n_taken < MAX_CHUNK_SAMPLES) begin
            sq_sum  = sq_sum + SUM_W'(mag) * SUM_W'(mag);
            n_taken = n_taken + 1'b1;
          end
        end
        if (in_last_of_chunk) close_chunk(in_forward_chunk);
      end
    end
    results_due = levels_due.size();
  end

endmodule

[tb/audio_level_meter_with_pts_tb.sv]
// Top of the level meter testbench: clock, reset, stimulus and verdict.
// Depends on alm_pkg, the channel interfaces, the RTL and alm_level_checker.
`timescale 1ns / 1ps

module audio_level_meter_with_pts_tb;
  import alm_pkg::*;

  typedef enum int {
    IDLE_NONE,
    IDLE_SOME,
    IDLE_FULL
  } idle_mode_t;

  localparam int HALF_PERIOD     = 5;
  localparam int RESET_CYCLES    = 11;
  localparam int MAX_WAIT        = 16;
  localparam int LATENCY_WAIT    = 160;
  localparam int HOLD_OFF_CYCLES = 1500;
  localparam int RAND_ITEMS      = 900;
  localparam int N_PHASES        = 7;
  localparam int HOLD_PHASE      = 2;
  localparam logic [CFG_IDX_W-1:0] FIRST_FREE_IDX = CFG_IDX_W'(REG_SAMPLE_RATE) + 1'b1;
  localparam logic [CFG_IDX_W-1:0] LAST_IDX       = '1;
  localparam logic [SAMPLE_W-1:0]  POS_FULL       = 16'h7FFF;
  localparam logic [SAMPLE_W-1:0]  NEG_FULL       = 16'h8000;

  logic       clk = 1'b0;
  logic       rst_n;
  int         mismatches;
  int         results_due;
  int         items_sent;
  int         phase_start;
  idle_mode_t src_mode;
  idle_mode_t snk_mode;
  logic       hold_req;

  // Settings walked by the random phases; the last one returns to reset values.
  int unsigned phase_channels[N_PHASES] = '{0, 8, 1, 15, 3, 6, 2};
  int unsigned phase_rate[N_PHASES]     = '{0, 192000, 1, 262143, 44100, 7, 48000};

  alm_in_if  in_ch();
  alm_out_if out_ch();
  alm_cfg_if cfg_ch();

  audio_level_meter_with_pts u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  alm_level_checker u_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_ch.valid),
    .in_ready          (in_ch.ready),
    .in_sample         (in_ch.sample),
    .in_has_sample     (in_ch.has_sample),
    .in_last_of_chunk  (in_ch.last_of_chunk),
    .in_forward_chunk  (in_ch.forward_chunk),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_rms_level     (out_ch.rms_level),
    .out_peak_level    (out_ch.peak_level),
    .out_chunk_pts     (out_ch.chunk_pts),
    .out_pts_advanced  (out_ch.pts_advanced),
    .out_chunk_samples (out_ch.chunk_samples),
    .cfg_valid         (cfg_ch.valid),
    .cfg_ready         (cfg_ch.ready),
    .cfg_index         (cfg_ch.index),
    .cfg_data          (cfg_ch.data),
    .mismatches        (mismatches),
    .results_due       (results_due)
  );

  always #HALF_PERIOD clk = ~clk;

  initial begin
    #8_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic int draw_wait(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: return 0;
      IDLE_SOME: return ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, MAX_WAIT)) : 0;
      default:   return int'($urandom_range(0, MAX_WAIT));
    endcase
  endfunction

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0:       return POS_FULL;
      1:       return NEG_FULL;
      2:       return $urandom_range(0, 1) ? SAMPLE_W'($urandom_range(0, 63))
                                           : SAMPLE_W'(-$urandom_range(0, 63));
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic send_item(input logic [SAMPLE_W-1:0] smp, input logic has,
                           input logic last, input logic fwd);
    int gap;
    gap = draw_wait(src_mode);
    @(negedge clk);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.sample        <= smp;
    in_ch.has_sample    <= has;
    in_ch.last_of_chunk <= last;
    in_ch.forward_chunk <= fwd;
    do @(posedge clk); while (!in_ch.ready);
    if (has || last) items_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Drop valid, drain every pending result, then let the block go quiet.
  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (results_due != 0) @(negedge clk);
    repeat (LATENCY_WAIT) @(negedge clk);
  endtask

  task automatic send_random_chunk();
    int   kind;
    int   len;
    logic bare_end;
    logic fwd;
    logic is_last;
    kind = $urandom_range(0, 19);
    if (kind == 0) len = 0;
    else if (kind < 3) len = $urandom_range(13, 64);
    else len = $urandom_range(1, 12);
    bare_end = (len == 0) || ($urandom_range(0, 3) == 0);
    fwd = 1'($urandom_range(0, 1));
    for (int i = 0; i < len; i++) begin
      // Sprinkle in empty items that carry neither a sample nor an end.
      if ($urandom_range(0, 19) == 0) send_item(rand_sample(), 1'b0, 1'b0, 1'($urandom));
      is_last = !bare_end && (i == len - 1);
      send_item(rand_sample(), 1'b1, is_last, is_last ? fwd : 1'($urandom));
    end
    if (bare_end) send_item(rand_sample(), 1'b0, 1'b1, fwd);
  endtask

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    int stall;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_req) begin
        stall = HOLD_OFF_CYCLES;
        hold_req = 1'b0;
      end else begin
        stall = draw_wait(snk_mode);
      end
      @(negedge clk);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  initial begin
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.sample        = '0;
    in_ch.has_sample    = 1'b0;
    in_ch.last_of_chunk = 1'b0;
    in_ch.forward_chunk = 1'b0;
    out_ch.ready        = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = REG_CHANNEL_COUNT;
    cfg_ch.data         = '0;
    hold_req            = 1'b0;
    src_mode            = IDLE_FULL;
    snk_mode            = IDLE_FULL;
    items_sent          = 0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty chunks, ignored items, extremes, alternating bit patterns.
    send_item(16'h0000, 1'b0, 1'b1, 1'b1);
    send_item(16'h0000, 1'b0, 1'b1, 1'b0);
    send_item(16'h1234, 1'b0, 1'b0, 1'b1);
    send_item(POS_FULL, 1'b1, 1'b0, 1'b1);
    send_item(NEG_FULL, 1'b1, 1'b1, 1'b1);
    send_item(16'h5555, 1'b1, 1'b0, 1'b0);
    send_item(16'hAAAA, 1'b1, 1'b1, 1'b0);
    send_item(16'h0000, 1'b1, 1'b1, 1'b1);
    send_item(16'hFFFF, 1'b1, 1'b0, 1'b0);
    send_item(16'h0001, 1'b1, 1'b0, 1'b1);
    send_item(16'hFFFF, 1'b0, 1'b1, 1'b1);
    send_item(NEG_FULL, 1'b1, 1'b1, 1'b0);
    repeat (3) send_item(16'h0000, 1'b0, 1'b1, 1'b1);
    settle();

    for (int p = 0; p < N_PHASES; p++) begin
      write_reg(REG_CHANNEL_COUNT, CFG_DATA_W'(phase_channels[p]));
      write_reg(REG_SAMPLE_RATE, CFG_DATA_W'(phase_rate[p]));
      write_reg(CFG_IDX_W'($urandom_range(FIRST_FREE_IDX, LAST_IDX)), CFG_DATA_W'($urandom));
      src_mode = idle_mode_t'(p % 3);
      snk_mode = idle_mode_t'((p + 1) % 3);
      if (p == HOLD_PHASE) hold_req = 1'b1;
      phase_start = items_sent;
      while (items_sent - phase_start < RAND_ITEMS / N_PHASES) send_random_chunk();
      settle();
    end

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
